// ----- hw/rtl/char_lcd_nibble_writer_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the character LCD nibble writer
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_WRITER_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITER_MACROS_SVH

// same-cycle implication
`define CLNW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CLNW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/clnw_pkg.sv -----
// ---------------------------------------------------------------------------
// clnw_pkg
// Types, codes and the power-up nibble table for the nibble writer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package clnw_pkg;

    typedef enum logic [1:0] {
        ACT_INIT  = 2'd0,
        ACT_INSTR = 2'd1,
        ACT_CHAR  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CFG_LINE_LENGTH = 2'd0,
        CFG_CHAR_WAIT   = 2'd1,
        CFG_LINE2_ADDR  = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_index_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  data;
        logic [7:0]  next_data;
        logic        string_start;
        logic [15:0] wait_us;
    } req_t;

    typedef struct packed {
        logic        rs;
        logic [3:0]  nibble;
        logic [15:0] wait_after_us;
        logic        last;
    } res_t;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic [3:0] idx;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       req_empty;
        logic       out_free;
        logic [3:0] count;
    } dp_status_t;

    typedef struct packed {
        logic [3:0]  nibble;
        logic [15:0] wait_us;
    } init_entry_t;

    localparam logic [3:0]  INIT_COUNT    = 4'd14;
    localparam logic [3:0]  BYTE_COUNT    = 4'd2;
    localparam logic [3:0]  LINE_COUNT    = 4'd4;
    localparam logic [7:0]  CMD_SET_ADDR  = 8'h80;
    localparam logic [7:0]  CHAR_BSLASH   = 8'h5C;
    localparam logic [7:0]  CHAR_N        = 8'h6E;
    localparam logic [7:0]  POS_MAX       = 8'hFF;
    localparam logic [7:0]  RST_LINE_LEN  = 8'd16;
    localparam logic [15:0] RST_CHAR_WAIT = 16'd40;
    localparam logic [6:0]  RST_LINE2     = 7'h40;

    function automatic init_entry_t init_nibble(input logic [3:0] idx);
        init_entry_t e;
        e = '{nibble: 4'h0, wait_us: 16'd0};
        case (idx) inside
            [4'd0:4'd2]:      e = '{nibble: 4'h3, wait_us: 16'd0};
            4'd3:             e = '{nibble: 4'h2, wait_us: 16'd40};
            4'd4:             e = '{nibble: 4'h2, wait_us: 16'd0};
            4'd5:             e = '{nibble: 4'h8, wait_us: 16'd40};
            4'd7:             e = '{nibble: 4'h8, wait_us: 16'd40};
            4'd9:             e = '{nibble: 4'h1, wait_us: 16'd2000};
            4'd11:            e = '{nibble: 4'h6, wait_us: 16'd80};
            4'd13:            e = '{nibble: 4'hC, wait_us: 16'd80};
            default:          e = '{nibble: 4'h0, wait_us: 16'd0};
        endcase
        return e;
    endfunction

endpackage

// ----- hw/rtl/clnw_datapath.sv -----
// ---------------------------------------------------------------------------
// clnw_datapath
// Request latch, string position, configuration and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module clnw_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  clnw_pkg::req_t       req,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  clnw_pkg::ctrl_cmd_t  cmd,
    output clnw_pkg::dp_status_t status,
    output logic                 out_valid,
    input  logic                 out_stall,
    output clnw_pkg::res_t       res
);
    import clnw_pkg::*;

    logic [7:0]  line_len_reg;
    logic [15:0] char_wait_reg;
    logic [6:0]  line2_reg;
    logic [7:0]  pos_reg, pos_next;
    action_t     act_reg;
    logic [7:0]  data_reg;
    logic [15:0] wait_reg;
    logic        line_reg, line_next;
    logic        out_valid_reg;
    res_t        res_reg, res_next;

    logic [7:0]  pos_eff;
    logic [7:0]  byte_sel;
    logic [15:0] wait_sel;
    logic        rs_sel;
    init_entry_t ie;

    always_comb
    begin
        pos_eff   = req.string_start ? 8'd0 : pos_reg;
        line_next = ((req.data == CHAR_BSLASH) && (req.next_data == CHAR_N))
                    || (pos_eff == line_len_reg);
        pos_next  = (pos_eff == POS_MAX) ? POS_MAX : pos_eff + 8'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len_reg  <= RST_LINE_LEN;
            char_wait_reg <= RST_CHAR_WAIT;
            line2_reg     <= RST_LINE2;
            pos_reg       <= 8'd0;
            act_reg       <= ACT_NONE;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_LINE_LENGTH: line_len_reg  <= cfg_data[7:0];
                    CFG_CHAR_WAIT:   char_wait_reg <= cfg_data;
                    CFG_LINE2_ADDR:  line2_reg     <= cfg_data[6:0];
                    CFG_UNUSED:      ;
                endcase
            end
            if (cmd.load)
            begin
                act_reg <= req.action;
                if (req.action == ACT_CHAR)
                begin
                    pos_reg <= pos_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            data_reg <= req.data;
            wait_reg <= req.wait_us;
            line_reg <= line_next;
        end
    end

    always_comb
    begin
        ie = init_nibble(cmd.idx);
        unique case (act_reg)
            ACT_INIT:  status.count = INIT_COUNT;
            ACT_INSTR: status.count = BYTE_COUNT;
            ACT_CHAR:  status.count = line_reg ? LINE_COUNT : BYTE_COUNT;
            ACT_NONE:  status.count = 4'd0;
        endcase
        status.req_empty = (req.action == ACT_NONE);
        status.out_free  = !out_valid_reg || !out_stall;

        rs_sel   = 1'b0;
        byte_sel = data_reg;
        wait_sel = wait_reg;
        if (act_reg == ACT_CHAR)
        begin
            wait_sel = char_wait_reg;
            if (line_reg && !cmd.idx[1])
            begin
                byte_sel = CMD_SET_ADDR | {1'b0, line2_reg};
            end
            else
            begin
                rs_sel = 1'b1;
            end
        end

        res_next.rs            = rs_sel;
        res_next.nibble        = cmd.idx[0] ? byte_sel[3:0] : byte_sel[7:4];
        res_next.wait_after_us = cmd.idx[0] ? wait_sel : 16'd0;
        if (act_reg == ACT_INIT)
        begin
            res_next.nibble        = ie.nibble;
            res_next.wait_after_us = ie.wait_us;
        end
        res_next.last = (cmd.idx == status.count - 4'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

// ----- hw/rtl/clnw_controller.sv -----
// ---------------------------------------------------------------------------
// clnw_controller
// Sequences the nibbles of one request into the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "char_lcd_nibble_writer_macros.svh"

module clnw_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  clnw_pkg::dp_status_t status,
    output clnw_pkg::ctrl_cmd_t  cmd
);
    import clnw_pkg::*;

    state_t     st_reg, st_next;
    logic [3:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            idx_reg <= 4'd0;
        end
        else
        begin
            st_reg  <= st_next;
            idx_reg <= idx_next;
        end
    end

    always_comb
    begin
        st_next  = st_reg;
        idx_next = idx_reg;
        cmd.load = 1'b0;
        cmd.emit = 1'b0;
        cmd.idx  = idx_reg;
        in_stall = 1'b1;
        unique case (st_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    idx_next = 4'd0;
                    if (!status.req_empty)
                    begin
                        st_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    idx_next = idx_reg + 4'd1;
                    if (idx_reg == status.count - 4'd1)
                    begin
                        st_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    `CLNW_ASSERT_NOW(a_emit_free, cmd.emit, status.out_free)
    `CLNW_ASSERT_NEXT(a_load_run, cmd.load && !status.req_empty, st_reg == ST_RUN)
    `CLNW_ASSERT_NEXT(a_last_idle, cmd.emit && idx_reg == status.count - 4'd1,
                      st_reg == ST_IDLE)
    `CLNW_ASSERT_NOW(a_idx_range, st_reg == ST_RUN, idx_reg < status.count)

endmodule

// ----- hw/rtl/char_lcd_nibble_writer.sv -----
// ---------------------------------------------------------------------------
// char_lcd_nibble_writer
// Turns init, instruction and string-character requests into 4-bit LCD
// nibble strobes with register select and post-strobe wait.
//
//   Channel  Handshake             Payload
//   req      in_valid / in_stall   clnw_pkg::req_t
//   res      out_valid / out_stall clnw_pkg::res_t
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A request is accepted in the idle state, then its nibbles follow: 2 for
// an instruction or plain character, 4 with a line change, 14 for init.
// The nibble sequencer emits at most one nibble per cycle into the output
// register; a stall on res holds the sequencer.
// Action 3 is accepted and produces nothing.
// Reset restores the configuration defaults and clears the string position.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module char_lcd_nibble_writer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  clnw_pkg::req_t req,
    output logic           out_valid,
    input  logic           out_stall,
    output clnw_pkg::res_t res,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [15:0]    cfg_data
);
    import clnw_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    clnw_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    clnw_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

endmodule

// ----- tb/char_lcd_nibble_writer_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Strobe checker for char_lcd_nibble_writer
// Watches the request, strobe and register channels. Keeps its own copy of
// the registers and the string position, predicts the nibble strobes of
// every accepted request and compares each strobe transfer, field by field,
// against the oldest prediction.
// ---------------------------------------------------------------------------
module char_lcd_nibble_writer_checker
    import clnw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  req_t        req,
    input  logic        out_valid,
    input  logic        out_stall,
    input  res_t        res,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        end_check,
    output int          mismatches,
    output int          pending,
    output int          strobes_checked
);

    localparam int MAX_PRINTED = 40;

    // power-up instructions sent after the three wake nibbles and the mode nibble, with their waits
    localparam logic [39:0] SETUP_BYTES = {8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};
    localparam logic [79:0] SETUP_WAITS = {16'd40, 16'd40, 16'd2000, 16'd80, 16'd80};
    localparam logic [3:0]  WAKE_NIBBLE = 4'h3;
    localparam logic [3:0]  MODE_NIBBLE = 4'h2;
    localparam logic [15:0] MODE_WAIT   = 16'd40;

    logic [7:0]  line_length = RST_LINE_LEN;
    logic [15:0] char_wait   = RST_CHAR_WAIT;
    logic [6:0]  line2_addr  = RST_LINE2;
    logic [7:0]  string_pos  = 8'd0;
    logic        leftovers_reported = 1'b0;
    res_t        expected_strobes [$];

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] ERROR %s", $time, what);
    endtask

    function automatic void push_strobe(input logic rs_bit, input logic [3:0] nib,
                                        input logic [15:0] wait_us);
        res_t s;
        s.rs            = rs_bit;
        s.nibble        = nib;
        s.wait_after_us = wait_us;
        s.last          = 1'b0;
        expected_strobes.push_back(s);
    endfunction

    // high nibble without wait, then low nibble with the byte's wait
    function automatic void push_byte(input logic rs_bit, input logic [7:0] value,
                                      input logic [15:0] wait_us);
        push_strobe(rs_bit, value[7:4], 16'd0);
        push_strobe(rs_bit, value[3:0], wait_us);
    endfunction

    function automatic void predict_strobes(input req_t r);
        int   before_count;
        int   i;
        res_t tail;
        before_count = expected_strobes.size();
        case (r.action)
            ACT_INIT:
            begin
                push_strobe(1'b0, WAKE_NIBBLE, 16'd0);
                push_strobe(1'b0, WAKE_NIBBLE, 16'd0);
                push_strobe(1'b0, WAKE_NIBBLE, 16'd0);
                push_strobe(1'b0, MODE_NIBBLE, MODE_WAIT);
                for (i = 0; i < 5; i++)
                    push_byte(1'b0, SETUP_BYTES[39 - 8 * i -: 8], SETUP_WAITS[79 - 16 * i -: 16]);
            end
            ACT_INSTR:
                push_byte(1'b0, r.data, r.wait_us);
            ACT_CHAR:
            begin
                if (r.string_start)
                    string_pos = 8'd0;
                if ((r.data == CHAR_BSLASH && r.next_data == CHAR_N) || string_pos == line_length)
                    push_byte(1'b0, CMD_SET_ADDR | {1'b0, line2_addr}, char_wait);
                push_byte(1'b1, r.data, char_wait);
                if (string_pos != POS_MAX)
                    string_pos = string_pos + 8'd1;
            end
            default:
                ;
        endcase
        if (expected_strobes.size() > before_count)
        begin
            tail = expected_strobes.pop_back();
            tail.last = 1'b1;
            expected_strobes.push_back(tail);
        end
    endfunction

    function automatic void apply_config(input logic [1:0] index, input logic [15:0] value);
        case (cfg_index_t'(index))
            CFG_LINE_LENGTH: line_length = value[7:0];
            CFG_CHAR_WAIT:   char_wait   = value;
            CFG_LINE2_ADDR:  line2_addr  = value[6:0];
            default:         ;
        endcase
    endfunction

    task automatic check_strobe(input res_t got);
        res_t want;
        if (expected_strobes.size() == 0)
        begin
            report_mismatch($sformatf("strobe with nothing predicted: rs %0b nibble %h wait %0d last %0b",
                                      got.rs, got.nibble, got.wait_after_us, got.last));
            return;
        end
        want = expected_strobes.pop_front();
        strobes_checked++;
        if (got.rs !== want.rs)
            report_mismatch($sformatf("strobe %0d rs %0b, predicted %0b",
                                      strobes_checked, got.rs, want.rs));
        if (got.nibble !== want.nibble)
            report_mismatch($sformatf("strobe %0d nibble %h, predicted %h",
                                      strobes_checked, got.nibble, want.nibble));
        if (got.wait_after_us !== want.wait_after_us)
            report_mismatch($sformatf("strobe %0d wait %0d, predicted %0d",
                                      strobes_checked, got.wait_after_us, want.wait_after_us));
        if (got.last !== want.last)
            report_mismatch($sformatf("strobe %0d last %0b, predicted %0b",
                                      strobes_checked, got.last, want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length = RST_LINE_LEN;
            char_wait   = RST_CHAR_WAIT;
            line2_addr  = RST_LINE2;
            string_pos  = 8'd0;
            expected_strobes.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_config(cfg_index, cfg_data);
            if (out_valid && !out_stall)
                check_strobe(res);
            if (in_valid && !in_stall)
                predict_strobes(req);
            if (end_check && !leftovers_reported)
            begin
                leftovers_reported = 1'b1;
                foreach (expected_strobes[k])
                    report_mismatch($sformatf("strobe never sent: rs %0b nibble %h wait %0d last %0b",
                                              expected_strobes[k].rs, expected_strobes[k].nibble,
                                              expected_strobes[k].wait_after_us,
                                              expected_strobes[k].last));
            end
            pending <= expected_strobes.size();
        end
    end

endmodule

// ----- tb/tb_char_lcd_nibble_writer.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for char_lcd_nibble_writer
// Drives init, instruction, string-character and unused requests, first a
// directed set, then random strings and noise under changing register
// settings and idle/stall mixes, including one string long enough to
// saturate the position. A separate checker predicts and compares.
// ---------------------------------------------------------------------------
module tb_char_lcd_nibble_writer;
    import clnw_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_STRING   = 260;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    req_t        req        = '0;
    logic        out_stall  = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic [1:0]  cfg_index  = 2'd0;
    logic [15:0] cfg_data   = 16'd0;
    logic        end_check  = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic        cfg_ready;
    res_t        res;

    int mismatches;
    int pending;
    int strobes_checked;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int items_sent  = 0;
    int cycle_count = 0;

    char_lcd_nibble_writer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req       (req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    char_lcd_nibble_writer_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req             (req),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .res             (res),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .end_check       (end_check),
        .mismatches      (mismatches),
        .pending         (pending),
        .strobes_checked (strobes_checked)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d strobes outstanding", cycle_count, pending);
            $display("FAIL char_lcd_nibble_writer");
            $finish;
        end
    end

    // hold valid across back-to-back transfers; drop it only for an idle gap
    task automatic send_request(input req_t r);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        req      <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    function automatic req_t random_request();
        req_t r;
        r.action       = action_t'($urandom_range(0, 3));
        r.data         = 8'($urandom);
        r.next_data    = 8'($urandom);
        r.string_start = 1'($urandom);
        r.wait_us      = 16'($urandom);
        return r;
    endfunction

    function automatic req_t random_instruction();
        req_t r;
        r = random_request();
        r.action = ACT_INSTR;
        case ($urandom_range(0, 3))
            0:       r.wait_us = 16'd0;
            1:       r.wait_us = 16'hFFFF;
            default: r.wait_us = 16'($urandom);
        endcase
        return r;
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic [7:0] next_ch, input logic start);
        req_t r;
        r.action       = ACT_CHAR;
        r.data         = ch;
        r.next_data    = next_ch;
        r.string_start = start;
        r.wait_us      = 16'($urandom);
        send_request(r);
    endtask

    task automatic send_string(input int len, input int instr_pct);
        logic [7:0] text [$];
        int         k;
        while (text.size() < len)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    text.push_back(CHAR_BSLASH);
                    text.push_back(CHAR_N);
                end
                1:       text.push_back(CHAR_BSLASH);
                2, 3:    text.push_back(8'($urandom));
                default: text.push_back(8'($urandom_range(32, 126)));
            endcase
        end
        for (k = 0; k < text.size(); k++)
        begin
            if ($urandom_range(0, 99) < instr_pct)
                send_request(random_instruction());
            send_char(text[k], (k + 1 < text.size()) ? text[k + 1] : 8'h00, k == 0);
        end
    endtask

    task automatic run_directed();
        req_t       r;
        logic [7:0] text [$];
        int         k;
        r = '0;
        r.action = ACT_INIT;
        send_request(r);
        r.action = ACT_INSTR;
        send_request(r);
        r.data         = 8'hFF;
        r.next_data    = 8'hFF;
        r.string_start = 1'b1;
        r.wait_us      = 16'hFFFF;
        send_request(r);
        // backslash at the line end also asks for a break: only one is sent
        text = '{8'h48, 8'h20, 8'h7E, CHAR_BSLASH, CHAR_N, 8'h00, 8'hFF, CHAR_BSLASH, 8'h41,
                 8'h80, 8'h01, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, CHAR_BSLASH, CHAR_N};
        for (k = 0; k < text.size(); k++)
        begin
            if (k == 10)
            begin
                r.action       = ACT_NONE;
                r.data         = CHAR_BSLASH;
                r.next_data    = CHAR_N;
                r.string_start = 1'b1;
                send_request(r);
            end
            send_char(text[k], (k + 1 < text.size()) ? text[k + 1] : 8'h00, k == 0);
        end
        send_char(8'h5A, 8'h00, 1'b1);
    endtask

    task automatic run_mixed(input int count);
        req_t r;
        int   stop_at;
        int   pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 9)
                send_string($urandom_range(1, 12), 5);
            else if (pick < 13)
                send_request(random_instruction());
            else if (pick < 15)
            begin
                r = random_request();
                r.action = ACT_INIT;
                send_request(r);
            end
            else if (pick < 17)
                send_request(random_request());
            else
                send_char(8'($urandom), $urandom_range(0, 1) ? CHAR_N : 8'($urandom), 1'b0);
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] line_word, input logic [15:0] wait_word,
                             input logic [15:0] addr_word, input logic touch_unused);
        write_reg(CFG_LINE_LENGTH, line_word);
        write_reg(CFG_CHAR_WAIT, wait_word);
        write_reg(CFG_LINE2_ADDR, addr_word);
        if (touch_unused)
            write_reg(CFG_UNUSED, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        idle_pct  = 32;
        stall_pct = 63;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain();

        configure({8'($urandom), 8'd5}, 16'd0, {9'($urandom), 7'd127}, 1'b1);
        run_mixed(10);
        drain();
        configure(16'($urandom_range(1, 12)), 16'($urandom), 16'($urandom), 1'b0);
        run_mixed(8);
        drain();

        idle_pct  = 63;
        stall_pct = 32;
        configure({8'($urandom), 8'd0}, 16'hFFFF, {9'($urandom), 7'd0}, 1'b0);
        run_mixed(12);
        drain();

        idle_pct  = 0;
        stall_pct = 0;
        configure(16'd255, 16'($urandom), 16'($urandom), 1'b0);
        send_string(LONG_STRING, 3);
        run_mixed(4);
        drain();

        end_check <= 1'b1;
        repeat (2) @(posedge clk);
        $display("Sent %0d requests, checked %0d strobes: power-up, instructions, strings with",
                 items_sent, strobes_checked);
        $display("line breaks and position saturation, unused action, four register settings.");
        if (mismatches == 0)
            $display("PASS char_lcd_nibble_writer");
        else
            $display("FAIL char_lcd_nibble_writer");
        $finish;
    end

endmodule
